// ===== hw/rtl/three_stacks_in_one_memory_core_defines.svh =====
// ----------------------------------------------------------------------------
// Three stacks in one memory: assertion macros
// Shared property shapes for the concurrent checks of the core.
// ----------------------------------------------------------------------------
`ifndef THREE_STACKS_IN_ONE_MEMORY_CORE_DEFINES_SVH
`define THREE_STACKS_IN_ONE_MEMORY_CORE_DEFINES_SVH

// Condition in this cycle requires a consequence in the same cycle.
`define TSM_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("core check failed");

// Condition in this cycle requires a consequence in the next cycle.
`define TSM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("core check failed");

// Condition in this cycle requires a delayed consequence.
`define TSM_ASSERT_TWO(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##2 (cons)) \
      else $error("core check failed");

`endif

// ===== hw/rtl/tsm_pkg.sv =====
// ----------------------------------------------------------------------------
// Three stacks in one memory: package
// Request and response types, status codes and shared constants.
// ----------------------------------------------------------------------------
package tsm_pkg;

   // Default sizing handed to the top level parameters.
   localparam int DEFAULT_MAX_CAPACITY = 16;
   localparam int DEFAULT_STACK_COUNT  = 3;

   // Width of the capacity register and of every depth counter.
   localparam int DEPTH_W = 5;
   localparam int WORD_W  = 32;

   // Base plus depth never exceeds four times the largest register value,
   // so seven bits always hold the raw address sum.
   localparam int ADDR_SUM_MIN_W = 7;

   localparam logic [DEPTH_W-1:0] CAPACITY_RESET = 5'd16;
   localparam logic signed [WORD_W-1:0] EMPTY_WORD = 32'sh8000_0000;

   typedef enum logic [0:0] {
      OP_PUSH = 1'b0,
      OP_POP  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STATUS_DONE       = 2'd0,
      STATUS_FULL       = 2'd1,
      STATUS_EMPTY      = 2'd2,
      STATUS_BAD_SELECT = 2'd3
   } status_type;

   typedef struct packed {
      op_type                   op;
      logic [1:0]               stack_select;
      logic signed [WORD_W-1:0] push_value;
   } req_type;

   typedef struct packed {
      status_type               status;
      logic signed [WORD_W-1:0] pop_value;
      logic [DEPTH_W-1:0]       depth_after;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic execute;
   } cmd_type;

endpackage

// ===== hw/rtl/tsm_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One write or one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
module tsm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 48
) (
   input  logic                     clock,
   input  logic                     write_enable,
   input  logic                     read_enable,
   input  logic [$clog2(DEPTH)-1:0] address,
   input  logic [WIDTH-1:0]         write_data,
   output logic [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   // Storage array and registered read port.
   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[address] <= write_data;
      end
      if (read_enable) begin
         read_data_ff <= mem_ff[address];
      end
   end

   assign read_data = read_data_ff;

endmodule

// ===== hw/rtl/tsm_controller.sv =====
// ----------------------------------------------------------------------------
// Three stacks in one memory: controller
// Sequences each request through capture, execute and respond.
// ----------------------------------------------------------------------------
module tsm_controller (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   output logic             rsp_strobe,
   output tsm_pkg::cmd_type cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXECUTE,
      ST_RESPOND
   } state_type;

   state_type state_ff;
   logic      busy_ff;
   logic      strobe_ff;

   // State and registered handshake outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         busy_ff   <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               strobe_ff <= 1'b0;
               if (start) begin
                  state_ff <= ST_EXECUTE;
                  busy_ff  <= 1'b1;
               end
            end
            ST_EXECUTE: begin
               state_ff  <= ST_RESPOND;
               strobe_ff <= 1'b1;
            end
            ST_RESPOND: begin
               state_ff  <= ST_IDLE;
               busy_ff   <= 1'b0;
               strobe_ff <= 1'b0;
            end
            default: begin
               state_ff  <= ST_IDLE;
               busy_ff   <= 1'b0;
               strobe_ff <= 1'b0;
            end
         endcase
      end
   end

   // The request is captured on the accepting edge; execute follows.
   assign cmd.capture = start && !busy_ff;
   assign cmd.execute = (state_ff == ST_EXECUTE);
   assign busy        = busy_ff;
   assign rsp_strobe  = strobe_ff;

endmodule

// ===== hw/rtl/tsm_datapath.sv =====
// ----------------------------------------------------------------------------
// Three stacks in one memory: datapath
// Capacity register, depth counters, address arithmetic and entry memory.
// ----------------------------------------------------------------------------
module tsm_datapath #(
   parameter int MAX_CAPACITY = tsm_pkg::DEFAULT_MAX_CAPACITY,
   parameter int STACK_COUNT  = tsm_pkg::DEFAULT_STACK_COUNT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  tsm_pkg::cmd_type               cmd,
   input  tsm_pkg::req_type               req_payload,
   input  logic                           csr_write_enable,
   input  logic [tsm_pkg::DEPTH_W-1:0]    csr_write_data,
   output tsm_pkg::rsp_type               rsp_payload
);

   localparam int STORE_DEPTH = STACK_COUNT * MAX_CAPACITY;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int SEL_W       = $clog2(STACK_COUNT);
   localparam int SUM_W       = (ADDR_W > tsm_pkg::ADDR_SUM_MIN_W) ?
                                ADDR_W : tsm_pkg::ADDR_SUM_MIN_W;
   localparam int DW          = tsm_pkg::DEPTH_W;
   localparam int WW          = tsm_pkg::WORD_W;

   tsm_pkg::req_type           req_ff;
   logic [DW-1:0]              capacity_ff;
   logic [DW-1:0]              depth_ff [STACK_COUNT];
   tsm_pkg::status_type        status_ff, status_in;
   logic [DW-1:0]              depth_after_ff, depth_after_in;
   logic                       use_ram_ff, use_ram_in;
   logic signed [WW-1:0]       word_ff, word_in;

   logic [DW-1:0]              cap;
   logic                       sel_ok;
   logic [SEL_W-1:0]           sel_idx;
   logic [DW-1:0]              depth_cur;
   logic [SUM_W-1:0]           base_sum;
   logic [SUM_W-1:0]           addr_sum;
   logic                       ram_write;
   logic                       ram_read;
   logic [WW-1:0]              ram_q;

   // A register value of zero acts as one; values above the maximum clamp.
   always_comb begin
      if (capacity_ff == '0) begin
         cap = DW'(1);
      end else if (32'(capacity_ff) > MAX_CAPACITY) begin
         cap = DW'(MAX_CAPACITY);
      end else begin
         cap = capacity_ff;
      end
   end

   assign sel_ok    = 32'(req_ff.stack_select) < STACK_COUNT;
   assign sel_idx   = req_ff.stack_select[SEL_W-1:0];
   assign depth_cur = depth_ff[sel_idx];
   assign base_sum  = SUM_W'(cap) * SUM_W'(req_ff.stack_select);

   // Decide the outcome of the captured request.
   always_comb begin
      status_in      = tsm_pkg::STATUS_DONE;
      depth_after_in = depth_cur;
      use_ram_in     = 1'b0;
      word_in        = '0;
      ram_write      = 1'b0;
      ram_read       = 1'b0;
      addr_sum       = base_sum + SUM_W'(depth_cur);
      if (!sel_ok) begin
         status_in      = tsm_pkg::STATUS_BAD_SELECT;
         depth_after_in = '0;
      end else if (req_ff.op == tsm_pkg::OP_PUSH) begin
         if (depth_cur >= cap) begin
            status_in = tsm_pkg::STATUS_FULL;
         end else begin
            ram_write      = cmd.execute;
            depth_after_in = depth_cur + DW'(1);
         end
      end else begin
         if (depth_cur == '0) begin
            status_in = tsm_pkg::STATUS_EMPTY;
            word_in   = tsm_pkg::EMPTY_WORD;
         end else begin
            addr_sum       = base_sum + SUM_W'(depth_cur) - SUM_W'(1);
            ram_read       = cmd.execute;
            use_ram_in     = 1'b1;
            depth_after_in = depth_cur - DW'(1);
         end
      end
   end

   // Control registers: capacity and per-stack depth counters.
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= tsm_pkg::CAPACITY_RESET;
         for (int i = 0; i < STACK_COUNT; i++) begin
            depth_ff[i] <= '0;
         end
      end else begin
         if (csr_write_enable) begin
            capacity_ff <= csr_write_data;
         end
         if (cmd.execute && sel_ok) begin
            depth_ff[sel_idx] <= depth_after_in;
         end
      end
   end

   // Request capture and response registers.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_payload;
      end
      if (cmd.execute) begin
         status_ff      <= status_in;
         depth_after_ff <= depth_after_in;
         use_ram_ff     <= use_ram_in;
         word_ff        <= word_in;
      end
   end

   tsm_ram #(
      .WIDTH (WW),
      .DEPTH (STORE_DEPTH)
   ) u_entry_store (
      .clock        (clock),
      .write_enable (ram_write),
      .read_enable  (ram_read),
      .address      (addr_sum[ADDR_W-1:0]),
      .write_data   (req_ff.push_value),
      .read_data    (ram_q)
   );

   // A successful pop takes its word straight from the memory read port.
   assign rsp_payload.status      = status_ff;
   assign rsp_payload.pop_value   = use_ram_ff ? $signed(ram_q) : word_ff;
   assign rsp_payload.depth_after = depth_after_ff;

endmodule

// ===== hw/rtl/three_stacks_in_one_memory_core.sv =====
// ----------------------------------------------------------------------------
// Three stacks in one memory: top level
// The strobe is high in the respond state, which follows the execute state
// entered on the accepting edge. A new request is taken only in idle, after
// execute (memory access) and respond; busy covers both states.
// Reset clears the depth counters and sets the capacity to sixteen; the entry
// memory needs no clearing. Responses cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
`include "three_stacks_in_one_memory_core_defines.svh"

module three_stacks_in_one_memory_core #(
   parameter int MAX_CAPACITY = tsm_pkg::DEFAULT_MAX_CAPACITY,
   parameter int STACK_COUNT  = tsm_pkg::DEFAULT_STACK_COUNT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  tsm_pkg::req_type            req_payload,
   output logic                        rsp_strobe,
   output tsm_pkg::rsp_type            rsp_payload,
   input  logic                        csr_write_enable,
   input  logic [tsm_pkg::DEPTH_W-1:0] csr_write_data
);

   tsm_pkg::cmd_type cmd;
   logic             rsp_is_empty;
   logic             rsp_is_full;
   logic             rsp_empty_shape;

   tsm_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd)
   );

   tsm_datapath #(
      .MAX_CAPACITY (MAX_CAPACITY),
      .STACK_COUNT  (STACK_COUNT)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_payload      (req_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_payload      (rsp_payload)
   );

   // Response classes used by the checks below.
   assign rsp_is_empty    = rsp_strobe && (rsp_payload.status == tsm_pkg::STATUS_EMPTY);
   assign rsp_is_full     = rsp_strobe && (rsp_payload.status == tsm_pkg::STATUS_FULL);
   assign rsp_empty_shape = (rsp_payload.depth_after == '0) &&
                            (rsp_payload.pop_value == tsm_pkg::EMPTY_WORD);

   // An accepted request always produces its response once execute has passed.
   `TSM_ASSERT_TWO(a_response_follows, clock, reset, start && !busy, rsp_strobe)

   // The strobe lasts one cycle.
   `TSM_ASSERT_NEXT(a_strobe_single, clock, reset, rsp_strobe, !rsp_strobe)

   // A refused pop reports an empty stack and the empty marker word.
   `TSM_ASSERT_SAME(a_empty_pop, clock, reset, rsp_is_empty, rsp_empty_shape)

   // A refused push returns no word.
   `TSM_ASSERT_SAME(a_full_push, clock, reset, rsp_is_full, rsp_payload.pop_value == '0)

endmodule

// ===== test/tb_three_stacks_in_one_memory_core.sv =====
// ----------------------------------------------------------------------------
// Three stacks in one memory: testbench
// Drives push and pop requests at the core, predicts every response from a
// model of its own, and compares the strobed responses field by field. A
// short directed table covers the edges, then random phases sweep the
// capacity register and the gaps between requests.
// ----------------------------------------------------------------------------
module tb_three_stacks_in_one_memory_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_STACKS = tsm_pkg::DEFAULT_STACK_COUNT;
   localparam int CAP_MAX    = tsm_pkg::DEFAULT_MAX_CAPACITY;
   localparam int STORE_SIZE = NUM_STACKS * CAP_MAX;
   localparam int DW         = tsm_pkg::DEPTH_W;

   // One line of the directed table: a capacity write or a request.
   typedef struct {
      bit                 is_cap_write;
      logic [DW-1:0]      cap_value;
      tsm_pkg::req_type   req;
      bit                 known;
      tsm_pkg::rsp_type   want;
   } table_row;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   tsm_pkg::req_type   req_payload = '0;
   logic               rsp_strobe;
   tsm_pkg::rsp_type   rsp_payload;
   logic               csr_write_enable = 1'b0;
   logic [DW-1:0]      csr_write_data = '0;

   // Model state: capacity register, per-stack depth and the shared memory.
   logic [DW-1:0]                     capacity_reg = tsm_pkg::CAPACITY_RESET;
   int                                depth_of [NUM_STACKS];
   logic signed [tsm_pkg::WORD_W-1:0] entry_mem [STORE_SIZE];
   bit                                entry_written [STORE_SIZE];

   tsm_pkg::rsp_type pending_responses [$];
   table_row         directed_rows [$];
   int               error_count = 0;
   int               request_count = 0;
   int               cap_write_count = 0;
   int               status_seen [4];

   three_stacks_in_one_memory_core dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_payload      (req_payload),
      .rsp_strobe       (rsp_strobe),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // A zero register acts as one entry, anything above the maximum as the maximum.
   function automatic int effective_capacity();
      if (capacity_reg == 0) return 1;
      if (capacity_reg > CAP_MAX) return CAP_MAX;
      return int'(capacity_reg);
   endfunction

   // Apply one request to the model state and return the response it causes.
   function automatic tsm_pkg::rsp_type predict_access(tsm_pkg::req_type r);
      tsm_pkg::rsp_type res;
      int               sel;
      int               cap;
      int               depth;
      int               addr;
      res.status      = tsm_pkg::STATUS_DONE;
      res.pop_value   = '0;
      res.depth_after = '0;
      sel = int'(r.stack_select);
      if (sel >= NUM_STACKS) begin
         res.status = tsm_pkg::STATUS_BAD_SELECT;
         return res;
      end
      cap   = effective_capacity();
      depth = depth_of[sel];
      if (r.op == tsm_pkg::OP_PUSH) begin
         if (depth >= cap) begin
            res.status = tsm_pkg::STATUS_FULL;
         end else begin
            addr = cap * sel + depth;
            entry_mem[addr]     = r.push_value;
            entry_written[addr] = 1'b1;
            depth++;
         end
      end else if (depth == 0) begin
         res.status    = tsm_pkg::STATUS_EMPTY;
         res.pop_value = tsm_pkg::EMPTY_WORD;
      end else begin
         depth--;
         addr = cap * sel + depth;
         res.pop_value = entry_mem[addr];
      end
      depth_of[sel]   = depth;
      res.depth_after = depth[DW-1:0];
      return res;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("%0t ns: mismatch on %s: got %h, expected %h", $time, what, got, want);
      error_count++;
   endtask

   // Offer one request and hold it until the core takes it.
   task automatic issue_request(tsm_pkg::req_type r, bit use_known,
                                tsm_pkg::rsp_type known);
      tsm_pkg::rsp_type predicted;
      req_payload <= r;
      start       <= 1'b1;
      do @(posedge clock); while (busy);
      predicted = predict_access(r);
      pending_responses.push_back(use_known ? known : predicted);
      request_count++;
   endtask

   // Leave start low for a random number of cycles.
   task automatic idle_gap(int percent);
      int n;
      n = 0;
      while ($urandom_range(99) < percent) n++;
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // Write the capacity register once every response is in and the core is quiet.
   task automatic set_capacity(logic [DW-1:0] value);
      start <= 1'b0;
      while (pending_responses.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      capacity_reg = value;
      cap_write_count++;
   endtask

   function automatic tsm_pkg::req_type random_request(int focus, int push_percent);
      tsm_pkg::req_type r;
      int               sel;
      int               addr;
      sel = ($urandom_range(99) < 50) ? focus : $urandom_range(NUM_STACKS - 1);
      if ($urandom_range(99) < 6) sel = 3;
      r.stack_select = sel[1:0];
      r.op = ($urandom_range(99) < push_percent) ? tsm_pkg::OP_PUSH : tsm_pkg::OP_POP;
      case ($urandom_range(9))
         0:       r.push_value = 32'h7FFF_FFFF;
         1:       r.push_value = 32'h8000_0000;
         2:       r.push_value = 32'h0000_0000;
         3:       r.push_value = 32'hFFFF_FFFF;
         default: r.push_value = $urandom;
      endcase
      // After a capacity change a pop may land on a slot no push ever filled.
      if (r.op == tsm_pkg::OP_POP && sel < NUM_STACKS && depth_of[sel] != 0) begin
         addr = effective_capacity() * sel + depth_of[sel] - 1;
         if (!entry_written[addr]) r.op = tsm_pkg::OP_PUSH;
      end
      return r;
   endfunction

   function automatic table_row req_row(tsm_pkg::op_type op, logic [1:0] sel,
                                        logic [31:0] v);
      table_row row;
      row.is_cap_write = 1'b0;
      row.cap_value    = '0;
      row.req.op           = op;
      row.req.stack_select = sel;
      row.req.push_value   = v;
      row.known = 1'b0;
      row.want  = '0;
      return row;
   endfunction

   function automatic table_row known_row(tsm_pkg::op_type op, logic [1:0] sel,
                                          logic [31:0] v, tsm_pkg::status_type st,
                                          logic [31:0] pv, int d);
      table_row row;
      row = req_row(op, sel, v);
      row.known            = 1'b1;
      row.want.status      = st;
      row.want.pop_value   = pv;
      row.want.depth_after = d[DW-1:0];
      return row;
   endfunction

   function automatic table_row cap_row(logic [DW-1:0] v);
      table_row row;
      row = req_row(tsm_pkg::OP_PUSH, 2'd0, 32'h0);
      row.is_cap_write = 1'b1;
      row.cap_value    = v;
      return row;
   endfunction

   // Compare each strobed response with the oldest prediction.
   always @(posedge clock) begin
      tsm_pkg::rsp_type want;
      if (!reset && rsp_strobe) begin
         if (pending_responses.size() == 0) begin
            report_mismatch("response with no request pending",
                            rsp_payload.pop_value, 32'h0);
         end else begin
            want = pending_responses.pop_front();
            if (rsp_payload.status !== want.status)
               report_mismatch("status", 32'(rsp_payload.status), 32'(want.status));
            if (rsp_payload.pop_value !== want.pop_value)
               report_mismatch("pop_value", rsp_payload.pop_value, want.pop_value);
            if (rsp_payload.depth_after !== want.depth_after)
               report_mismatch("depth_after", 32'(rsp_payload.depth_after),
                               32'(want.depth_after));
            status_seen[want.status]++;
         end
      end
   end

   // Main sequence: reset, directed table, random phases, drain.
   initial begin
      logic [DW-1:0]    phase_caps [8];
      int               phase_idle [8];
      int               focus;
      int               push_percent;
      tsm_pkg::req_type r;

      for (int i = 0; i < NUM_STACKS; i++) depth_of[i] = 0;
      for (int i = 0; i < STORE_SIZE; i++) begin
         entry_mem[i]     = '0;
         entry_written[i] = 1'b0;
      end

      // Empty pops, bad selects, extreme words, then capacity lowered under
      // a stack that holds entries, a zero register and an oversized one.
      directed_rows.push_back(known_row(tsm_pkg::OP_POP, 2'd0, 32'h1234_5678,
                                        tsm_pkg::STATUS_EMPTY, tsm_pkg::EMPTY_WORD, 0));
      directed_rows.push_back(known_row(tsm_pkg::OP_POP, 2'd2, 32'h0,
                                        tsm_pkg::STATUS_EMPTY, tsm_pkg::EMPTY_WORD, 0));
      directed_rows.push_back(known_row(tsm_pkg::OP_PUSH, 2'd3, 32'hDEAD_BEEF,
                                        tsm_pkg::STATUS_BAD_SELECT, 32'h0, 0));
      directed_rows.push_back(known_row(tsm_pkg::OP_POP, 2'd3, 32'h0,
                                        tsm_pkg::STATUS_BAD_SELECT, 32'h0, 0));
      directed_rows.push_back(known_row(tsm_pkg::OP_PUSH, 2'd0, 32'h7FFF_FFFF,
                                        tsm_pkg::STATUS_DONE, 32'h0, 1));
      directed_rows.push_back(known_row(tsm_pkg::OP_PUSH, 2'd0, 32'h8000_0000,
                                        tsm_pkg::STATUS_DONE, 32'h0, 2));
      directed_rows.push_back(known_row(tsm_pkg::OP_PUSH, 2'd1, 32'h0000_0000,
                                        tsm_pkg::STATUS_DONE, 32'h0, 1));
      directed_rows.push_back(known_row(tsm_pkg::OP_PUSH, 2'd2, 32'hFFFF_FFFF,
                                        tsm_pkg::STATUS_DONE, 32'h0, 1));
      directed_rows.push_back(req_row(tsm_pkg::OP_PUSH, 2'd0, 32'h5555_5555));
      directed_rows.push_back(req_row(tsm_pkg::OP_PUSH, 2'd0, 32'hAAAA_AAAA));
      directed_rows.push_back(req_row(tsm_pkg::OP_PUSH, 2'd0, 32'h0000_0001));
      directed_rows.push_back(req_row(tsm_pkg::OP_POP, 2'd0, 32'h0));
      directed_rows.push_back(req_row(tsm_pkg::OP_POP, 2'd2, 32'h0));
      directed_rows.push_back(cap_row(5'd2));
      directed_rows.push_back(known_row(tsm_pkg::OP_PUSH, 2'd0, 32'h1111_1111,
                                        tsm_pkg::STATUS_FULL, 32'h0, 4));
      directed_rows.push_back(req_row(tsm_pkg::OP_POP, 2'd0, 32'h0));
      directed_rows.push_back(req_row(tsm_pkg::OP_POP, 2'd1, 32'h0));
      directed_rows.push_back(req_row(tsm_pkg::OP_PUSH, 2'd1, 32'h0BAD_F00D));
      directed_rows.push_back(cap_row(5'd0));
      directed_rows.push_back(req_row(tsm_pkg::OP_PUSH, 2'd2, 32'h2222_2222));
      directed_rows.push_back(known_row(tsm_pkg::OP_PUSH, 2'd2, 32'h3333_3333,
                                        tsm_pkg::STATUS_FULL, 32'h0, 1));
      directed_rows.push_back(cap_row(5'd31));
      directed_rows.push_back(req_row(tsm_pkg::OP_PUSH, 2'd2, 32'h4444_4444));
      directed_rows.push_back(req_row(tsm_pkg::OP_POP, 2'd2, 32'h0));
      directed_rows.push_back(req_row(tsm_pkg::OP_POP, 2'd2, 32'h0));
      directed_rows.push_back(req_row(tsm_pkg::OP_POP, 2'd0, 32'h0));

      phase_caps = '{5'd1, 5'd3, 5'd16, 5'd0, 5'd31, 5'd5, 5'd2, 5'd0};
      phase_caps[7] = DW'($urandom_range(31));
      phase_idle = '{0, 46, 11, 0, 46, 11, 0, 46};

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].is_cap_write)
            set_capacity(directed_rows[i].cap_value);
         else
            issue_request(directed_rows[i].req, directed_rows[i].known,
                          directed_rows[i].want);
      end

      // Random phases: each sets a capacity and a gap rate, and alternates
      // filling and draining a favored stack so full and empty are reached.
      for (int p = 0; p < 8; p++) begin
         set_capacity(phase_caps[p]);
         focus = 0;
         push_percent = 75;
         for (int n = 0; n < 112; n++) begin
            if (n % 40 == 0) begin
               focus = $urandom_range(NUM_STACKS - 1);
               push_percent = (push_percent == 75) ? 25 : 75;
            end
            r = random_request(focus, push_percent);
            issue_request(r, 1'b0, '0);
            idle_gap(phase_idle[p]);
         end
      end

      start <= 1'b0;
      while (pending_responses.size() != 0) @(posedge clock);
      repeat (5) @(posedge clock);

      $display("Ran %0d requests across %0d capacity writes.", request_count, cap_write_count);
      $display("Responses seen: %0d done, %0d full, %0d empty, %0d bad select.",
               status_seen[tsm_pkg::STATUS_DONE], status_seen[tsm_pkg::STATUS_FULL],
               status_seen[tsm_pkg::STATUS_EMPTY], status_seen[tsm_pkg::STATUS_BAD_SELECT]);
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // Watchdog far beyond the slowest legal run.
   initial begin
      #2_000_000;
      $display("FAIL");
      $finish;
   end

endmodule
